// ===== design/fla_pkg.sv =====
// shared types and constants for the free list block allocator
// no dependencies; imported by fla_front, fla_back and the top level
package fla_pkg;

   // pool geometry
   localparam int POOL_BLOCKS = 1024;
   localparam int IDX_W       = $clog2(POOL_BLOCKS);
   localparam int LINK_W      = IDX_W + 1;
   localparam int MAX_BULK    = 64;
   localparam int COUNT_W     = 7;

   // link with the none bit set marks the end of a list
   localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {IDX_W{1'b0}}};

   // command codes
   localparam logic [1:0] CMD_PUSH      = 2'd0;
   localparam logic [1:0] CMD_POP       = 2'd1;
   localparam logic [1:0] CMD_BULK_PUSH = 2'd2;
   localparam logic [1:0] CMD_BULK_POP  = 2'd3;

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // classified command as held in the queue
   typedef struct packed {
      logic [1:0]         cmd;
      logic [IDX_W-1:0]   block;
      logic [IDX_W-1:0]   tail;
      logic [COUNT_W-1:0] want;
   } item_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LINK = 2'b10
   } state_type;

endpackage

// ===== design/free_list_block_allocator_core.sv =====
// push or batch push: head and link are written when the back end takes the command, no beat
// pop: first beat follows the registered read of the head's link; an empty list instead gives
// one flagged beat; batch pop: one beat a cycle while not stalled, set by chained link reads
// throughput: one push per cycle sustained when no pop walk runs; one link read per pop beat
// reset: head cleared to none (list empty), queue emptied; link memory not cleared
// top level: free list block allocator; instantiates fla_front and fla_back, uses fla_pkg
module free_list_block_allocator_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_cmd,
   input  logic [fla_pkg::IDX_W-1:0]   req_block_index,
   input  logic [fla_pkg::IDX_W-1:0]   req_tail_index,
   input  logic [fla_pkg::COUNT_W-1:0] req_count,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [fla_pkg::IDX_W-1:0]   rsp_out_index,
   output logic                        rsp_empty_res,
   output logic                        rsp_last
);
   import fla_pkg::*;

   logic     item_valid;
   item_type item;
   logic     item_take;

   // accept and classify
   fla_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_block_index (req_block_index),
      .req_tail_index  (req_tail_index),
      .req_count       (req_count),
      .item_valid      (item_valid),
      .item            (item),
      .item_take       (item_take)
   );

   // execute against the list
   fla_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item          (item),
      .item_take     (item_take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_index (rsp_out_index),
      .rsp_empty_res (rsp_empty_res),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== design/fla_front.sv =====
// front end: accepts request beats, normalizes the batch count, queues commands
// depends on fla_pkg
module fla_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_cmd,
   input  logic [fla_pkg::IDX_W-1:0]   req_block_index,
   input  logic [fla_pkg::IDX_W-1:0]   req_tail_index,
   input  logic [fla_pkg::COUNT_W-1:0] req_count,
   output logic                        item_valid,
   output fla_pkg::item_type           item,
   input  logic                        item_take
);
   import fla_pkg::*;

   item_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       fill_ff, fill_in;
   logic                  push_q, pop_q;
   logic [COUNT_W-1:0]    want;
   item_type              new_item;

   // batch size: non-batch commands and zero count take one, counts above MAX_BULK saturate
   always_comb begin
      if (req_cmd != CMD_BULK_POP || req_count == '0) begin
         want = COUNT_W'(1);
      end else if (req_count > COUNT_W'(MAX_BULK)) begin
         want = COUNT_W'(MAX_BULK);
      end else begin
         want = req_count;
      end
   end

   assign new_item.cmd   = req_cmd;
   assign new_item.block = req_block_index;
   assign new_item.tail  = req_tail_index;
   assign new_item.want  = want;

   // queue control
   assign req_stall  = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign push_q     = req_valid && !req_stall;
   assign item_valid = (fill_ff != '0);
   assign pop_q      = item_take && item_valid;
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_q ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_q ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_q && !pop_q) begin
         fill_in = fill_ff + (QPTR_W+1)'(1);
      end else if (pop_q && !push_q) begin
         fill_in = fill_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_q) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== design/fla_back.sv =====
// back end: head register, next-link memory, list walk and response register
// depends on fla_pkg
module fla_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   input  fla_pkg::item_type         item,
   output logic                      item_take,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [fla_pkg::IDX_W-1:0] rsp_out_index,
   output logic                      rsp_empty_res,
   output logic                      rsp_last
);
   import fla_pkg::*;

   state_type             state_ff, state_in;
   logic [LINK_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]      cut_ff, cut_in;
   logic [COUNT_W-1:0]    n_ff, n_in;
   logic [COUNT_W-1:0]    want_ff, want_in;
   logic                  bulk_ff, bulk_in;

   logic [LINK_W-1:0]     link_mem [POOL_BLOCKS];
   logic [LINK_W-1:0]     link_rd_ff;
   logic                  rd_en, wr_en;
   logic [IDX_W-1:0]      rd_addr, wr_addr;
   logic [LINK_W-1:0]     wr_data;

   logic                  rsp_valid_ff;
   logic [IDX_W-1:0]      rsp_index_ff;
   logic                  rsp_empty_ff, rsp_last_ff;
   logic                  out_free;
   logic                  emit, emit_empty, emit_last;
   logic [IDX_W-1:0]      emit_index;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // command sequencer
   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      cut_in     = cut_ff;
      n_in       = n_ff;
      want_in    = want_ff;
      bulk_in    = bulk_ff;
      item_take  = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = cut_ff;
      wr_en      = 1'b0;
      wr_addr    = item.block;
      wr_data    = head_ff;
      emit       = 1'b0;
      emit_index = cut_ff;
      emit_empty = 1'b0;
      emit_last  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               case (item.cmd)
                  CMD_PUSH: begin
                     wr_en     = 1'b1;
                     wr_addr   = item.block;
                     head_in   = {1'b0, item.block};
                     item_take = 1'b1;
                  end
                  CMD_BULK_PUSH: begin
                     wr_en     = 1'b1;
                     wr_addr   = item.tail;
                     head_in   = {1'b0, item.block};
                     item_take = 1'b1;
                  end
                  default: begin
                     if (head_ff[IDX_W]) begin
                        // empty list: one flagged beat
                        if (out_free) begin
                           emit       = 1'b1;
                           emit_index = '0;
                           emit_empty = 1'b1;
                           emit_last  = 1'b1;
                           item_take  = 1'b1;
                        end
                     end else begin
                        // start the walk at the top of the list
                        rd_en     = 1'b1;
                        rd_addr   = head_ff[IDX_W-1:0];
                        cut_in    = head_ff[IDX_W-1:0];
                        n_in      = COUNT_W'(1);
                        want_in   = item.want;
                        bulk_in   = (item.cmd == CMD_BULK_POP);
                        item_take = 1'b1;
                        state_in  = ST_LINK;
                     end
                  end
               endcase
            end
         end
         ST_LINK: begin
            // link of the current block is in link_rd_ff
            if (out_free) begin
               emit = 1'b1;
               if (n_ff < want_ff && !link_rd_ff[IDX_W]) begin
                  cut_in  = link_rd_ff[IDX_W-1:0];
                  n_in    = n_ff + COUNT_W'(1);
                  rd_en   = 1'b1;
                  rd_addr = link_rd_ff[IDX_W-1:0];
               end else begin
                  emit_last = 1'b1;
                  head_in   = link_rd_ff;
                  wr_en     = bulk_ff;
                  wr_addr   = cut_ff;
                  wr_data   = LINK_NONE;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= LINK_NONE;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      cut_ff  <= cut_in;
      n_ff    <= n_in;
      want_ff <= want_in;
      bulk_ff <= bulk_in;
   end

   // next-link memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         link_rd_ff <= link_mem[rd_addr];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_index_ff <= emit_index;
         rsp_empty_ff <= emit_empty;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // walk count stays within the requested batch
   a_walk_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LINK) |-> (n_ff != '0 && n_ff <= want_ff))
      else $error("batch walk count out of range");

   // an empty beat is only sent while the list is empty
   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_empty) |-> head_ff[IDX_W])
      else $error("empty beat with a non-empty list");

   // memory is never read and written in the same cycle
   a_mem_port: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("link memory read and write collide");

   // the final beat of a walk returns the sequencer to idle
   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LINK && emit && emit_last) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after last beat");
`endif

endmodule

// ===== tb/tb_free_list_block_allocator_core.sv =====
// testbench for free_list_block_allocator_core: a directed table, then random free list traffic
// every rsp beat is checked against a typed answer or an in-bench model of head and link memory
// depends on fla_pkg and the allocator rtl
`timescale 1ns / 100ps

module tb_free_list_block_allocator_core;
   import fla_pkg::*;

   localparam int RANDOM_ITEMS = 385;
   localparam int PLAN_ROWS    = 25;
   localparam int DRAIN_CYCLES = 16;
   localparam int COUNT_TOP    = (1 << COUNT_W) - 1;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [IDX_W-1:0]   blk;
      logic [IDX_W-1:0]   tail;
      logic [COUNT_W-1:0] cnt;
   } alloc_req_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             is_empty;
      logic             is_last;
   } grant_type;

   typedef struct packed {
      alloc_req_type req;
      logic          typed;
      grant_type     answer;
   } plan_row_type;

   localparam logic      TYPED        = 1'b1;
   localparam logic      PRED         = 1'b0;
   localparam grant_type EMPTY_ANSWER = '{10'd0, 1'b1, 1'b1};
   localparam grant_type FROM_MODEL   = '{10'd0, 1'b0, 1'b0};

   // directed part: typed answers only where they are obvious
   plan_row_type plan [0:PLAN_ROWS-1] = '{
      '{'{CMD_POP,       10'd0,    10'd0,    7'd0},   TYPED, EMPTY_ANSWER},
      '{'{CMD_BULK_POP,  10'd0,    10'd1023, 7'd0},   TYPED, EMPTY_ANSWER},
      '{'{CMD_BULK_PUSH, 10'd0,    10'd0,    7'd127}, PRED,  FROM_MODEL},
      '{'{CMD_PUSH,      10'd1023, 10'd1023, 7'd127}, PRED,  FROM_MODEL},
      '{'{CMD_POP,       10'd0,    10'd0,    7'd0},   TYPED, '{10'd1023, 1'b0, 1'b1}},
      '{'{CMD_POP,       10'd1023, 10'd0,    7'd64},  TYPED, '{10'd0, 1'b0, 1'b1}},
      '{'{CMD_POP,       10'd0,    10'd0,    7'd0},   TYPED, EMPTY_ANSWER},
      '{'{CMD_PUSH,      10'd5,    10'd0,    7'd0},   PRED,  FROM_MODEL},
      '{'{CMD_PUSH,      10'd6,    10'd0,    7'd0},   PRED,  FROM_MODEL},
      '{'{CMD_PUSH,      10'd7,    10'd0,    7'd0},   PRED,  FROM_MODEL},
      '{'{CMD_PUSH,      10'd8,    10'd0,    7'd0},   PRED,  FROM_MODEL},
      '{'{CMD_BULK_POP,  10'd0,    10'd0,    7'd0},   TYPED, '{10'd8, 1'b0, 1'b1}},
      '{'{CMD_BULK_POP,  10'd0,    10'd0,    7'd2},   PRED,  FROM_MODEL},
      '{'{CMD_BULK_POP,  10'd0,    10'd0,    7'd127}, TYPED, '{10'd5, 1'b0, 1'b1}},
      '{'{CMD_BULK_POP,  10'd0,    10'd0,    7'd1},   TYPED, EMPTY_ANSWER},
      '{'{CMD_BULK_PUSH, 10'd7,    10'd6,    7'd0},   PRED,  FROM_MODEL},
      '{'{CMD_BULK_PUSH, 10'd1023, 10'd1023, 7'd0},   PRED,  FROM_MODEL},
      '{'{CMD_BULK_POP,  10'd0,    10'd0,    7'd64},  PRED,  FROM_MODEL},
      '{'{CMD_PUSH,      10'd3,    10'd0,    7'd0},   PRED,  FROM_MODEL},
      '{'{CMD_BULK_PUSH, 10'd3,    10'd3,    7'd0},   PRED,  FROM_MODEL},
      '{'{CMD_BULK_POP,  10'd0,    10'd0,    7'd127}, PRED,  FROM_MODEL},
      '{'{CMD_BULK_PUSH, 10'd3,    10'd3,    7'd0},   PRED,  FROM_MODEL},
      '{'{CMD_BULK_POP,  10'd0,    10'd0,    7'd64},  PRED,  FROM_MODEL},
      '{'{CMD_POP,       10'd0,    10'd0,    7'd0},   TYPED, '{10'd3, 1'b0, 1'b1}},
      '{'{CMD_POP,       10'd0,    10'd0,    7'd0},   TYPED, EMPTY_ANSWER}
   };

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_cmd;
   logic [IDX_W-1:0]   req_block_index;
   logic [IDX_W-1:0]   req_tail_index;
   logic [COUNT_W-1:0] req_count;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [IDX_W-1:0]   rsp_out_index;
   logic               rsp_empty_res;
   logic               rsp_last;

   // free list mirror: head register and link memory with written flags
   logic [LINK_W-1:0] top_link = LINK_NONE;
   logic [LINK_W-1:0] chain [POOL_BLOCKS];
   bit                chain_set [POOL_BLOCKS];

   grant_type step_grants [$];
   grant_type due_grants [$];

   // stimulus bookkeeping: blocks the user holds, batches cut by batch pops
   bit                   held [POOL_BLOCKS];
   logic [IDX_W-1:0]     spare_q [$];
   logic [2*IDX_W-1:0]   cut_batches [$];

   int unsigned hold_stretch = 0;
   int unsigned tx_rush      = 0;
   bit          tx_calm      = 1'b0;
   bit          rx_calm      = 1'b0;

   int mismatches  = 0;
   int beats_seen  = 0;
   int empties     = 0;
   int longest_cut = 0;
   int cmd_seen [4];

   free_list_block_allocator_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_block_index (req_block_index),
      .req_tail_index  (req_tail_index),
      .req_count       (req_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_index   (rsp_out_index),
      .rsp_empty_res   (rsp_empty_res),
      .rsp_last        (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // apply one accepted command to the mirror, leave its answers in step_grants
   function automatic void free_list_apply(input alloc_req_type r);
      logic [LINK_W-1:0] cut;
      int unsigned       want;
      int unsigned       handed;
      step_grants.delete();
      if (r.cmd == CMD_PUSH) begin
         chain[r.blk]     = top_link;
         chain_set[r.blk] = 1'b1;
         top_link         = {1'b0, r.blk};
      end else if (r.cmd == CMD_BULK_PUSH) begin
         // inner links are already there, only the tail is tied to the old top
         chain[r.tail]     = top_link;
         chain_set[r.tail] = 1'b1;
         top_link          = {1'b0, r.blk};
      end else if (top_link[IDX_W]) begin
         step_grants.push_back(EMPTY_ANSWER);
      end else if (r.cmd == CMD_POP) begin
         step_grants.push_back(grant_type'{top_link[IDX_W-1:0], 1'b0, 1'b1});
         top_link = chain[top_link[IDX_W-1:0]];
      end else begin
         // zero means one, anything past the bulk limit saturates
         want   = (r.cnt == 0) ? 1 : (r.cnt > MAX_BULK) ? MAX_BULK : r.cnt;
         cut    = top_link;
         handed = 1;
         while (handed < want && !chain[cut[IDX_W-1:0]][IDX_W]) begin
            step_grants.push_back(grant_type'{cut[IDX_W-1:0], 1'b0, 1'b0});
            cut = chain[cut[IDX_W-1:0]];
            handed++;
         end
         step_grants.push_back(grant_type'{cut[IDX_W-1:0], 1'b0, 1'b1});
         top_link              = chain[cut[IDX_W-1:0]];
         chain[cut[IDX_W-1:0]] = LINK_NONE;
      end
   endfunction

   // offer one command, wait for the beat to be taken, then record what it should give
   task automatic offer(input alloc_req_type r, input logic typed,
                        input grant_type typed_answer);
      int unsigned       gap;
      logic [LINK_W-1:0] at;
      if (tx_rush != 0) begin
         gap = 0;
         tx_rush--;
      end else begin
         gap = tx_calm ? 0 : $urandom_range(0, 11);
      end
      if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= r.cmd;
      req_block_index <= r.blk;
      req_tail_index  <= r.tail;
      req_count       <= r.cnt;
      @(posedge clock);
      while (req_stall) @(posedge clock);

      // beat taken at this edge
      free_list_apply(r);
      cmd_seen[r.cmd]++;
      if (typed) begin
         due_grants.push_back(typed_answer);
      end else begin
         foreach (step_grants[k]) due_grants.push_back(step_grants[k]);
      end

      // track ownership so later pushes return blocks the user really holds
      foreach (step_grants[k]) begin
         if (!step_grants[k].is_empty) begin
            held[step_grants[k].idx] = 1'b1;
            spare_q.push_back(step_grants[k].idx);
         end
      end
      if (step_grants.size() > longest_cut) longest_cut = step_grants.size();
      if (r.cmd == CMD_BULK_POP && !step_grants[0].is_empty) begin
         cut_batches.push_back({step_grants[0].idx, step_grants[$].idx});
      end
      if (r.cmd == CMD_PUSH) held[r.blk] = 1'b0;
      if (r.cmd == CMD_BULK_PUSH) begin
         at = {1'b0, r.blk};
         for (int k = 0; k < MAX_BULK && !at[IDX_W]; k++) begin
            held[at[IDX_W-1:0]] = 1'b0;
            at = (at[IDX_W-1:0] == r.tail) ? LINK_NONE : chain[at[IDX_W-1:0]];
         end
      end
   endtask

   task automatic flag_mismatch(input string what, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      mismatches++;
      if (mismatches <= 10) begin
         $display("beat %0d: %s expected %0d, got %0d", beats_seen, what, want_v, got_v);
      end
   endtask

   // rsp side: compare every taken beat with the oldest pending answer
   always @(posedge clock) begin
      grant_type want_g;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (rsp_empty_res === 1'b1) empties++;
         if (due_grants.size() == 0) begin
            flag_mismatch("unexpected beat, out_index", 32'd0, 32'(rsp_out_index));
         end else begin
            want_g = due_grants.pop_front();
            if (rsp_out_index !== want_g.idx)
               flag_mismatch("out_index", 32'(want_g.idx), 32'(rsp_out_index));
            if (rsp_empty_res !== want_g.is_empty)
               flag_mismatch("empty_res", 32'(want_g.is_empty), 32'(rsp_empty_res));
            if (rsp_last !== want_g.is_last)
               flag_mismatch("last", 32'(want_g.is_last), 32'(rsp_last));
         end
      end
   end

   // rsp stall: random pause per beat, calm stretches, and one long hold on request
   initial begin
      int unsigned pause;
      rsp_stall = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_stretch != 0) begin
            pause        = hold_stretch;
            hold_stretch = 0;
         end else begin
            pause = rx_calm ? 0 : $urandom_range(0, 11);
         end
         if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
         if (pause != 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // main sequence: reset, directed table, random traffic, drain
   initial begin
      alloc_req_type      r;
      int unsigned        roll;
      int unsigned        pick;
      logic [2*IDX_W-1:0] span;
      logic [LINK_W-1:0]  at;
      int                 visit_mark [POOL_BLOCKS];
      bit                 safe;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_PUSH;
      req_block_index = '0;
      req_tail_index  = '0;
      req_count       = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) offer(plan[i].req, plan[i].typed, plan[i].answer);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // back pressure: long rsp hold while requests keep coming back to back
         if (i == 100) begin
            hold_stretch = 260;
            tx_rush      = 40;
         end
         // let the block run dry before going on
         if (i == 180 || i == 300) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (due_grants.size() != 0) @(posedge clock);
         end

         roll   = $urandom_range(0, 99);
         r.blk  = IDX_W'($urandom);
         r.tail = IDX_W'($urandom);
         r.cnt  = COUNT_W'($urandom);
         if (roll < 45) begin
            r.cmd = CMD_PUSH;
            // mostly give back a block that was handed out, otherwise any block
            while (spare_q.size() != 0 && !held[spare_q[0]]) spare_q.delete(0);
            if (spare_q.size() != 0 && $urandom_range(0, 3) != 0) begin
               r.blk = spare_q.pop_front();
            end
         end else if (roll < 57) begin
            r.cmd = CMD_POP;
         end else if (roll < 80) begin
            r.cmd = CMD_BULK_POP;
            pick  = $urandom_range(0, 9);
            if (pick < 7) r.cnt = COUNT_W'($urandom_range(0, 6));
            else if (pick < 9) r.cnt = COUNT_W'($urandom_range(7, MAX_BULK));
            else r.cnt = COUNT_W'($urandom_range(MAX_BULK + 1, COUNT_TOP));
         end else begin
            r.cmd = CMD_BULK_PUSH;
            if (cut_batches.size() != 0 && $urandom_range(0, 3) != 0) begin
               pick = $urandom_range(0, cut_batches.size() - 1);
               span = cut_batches[pick];
               cut_batches.delete(pick);
               r.blk  = span[2*IDX_W-1:IDX_W];
               r.tail = span[IDX_W-1:0];
            end
            // walk from the batch head; a never-written link before the tail is illegal,
            // so fall back to a one-block batch
            at   = {1'b0, r.blk};
            safe = 1'b1;
            while (!at[IDX_W] && at[IDX_W-1:0] != r.tail &&
                   visit_mark[at[IDX_W-1:0]] != i + 1) begin
               if (!chain_set[at[IDX_W-1:0]]) begin
                  safe = 1'b0;
                  at   = LINK_NONE;
               end else begin
                  visit_mark[at[IDX_W-1:0]] = i + 1;
                  at = chain[at[IDX_W-1:0]];
               end
            end
            if (!safe) r.tail = r.blk;
         end
         offer(r, PRED, FROM_MODEL);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (due_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d pushes, %0d pops, %0d batch pushes, %0d batch pops",
               cmd_seen[CMD_PUSH], cmd_seen[CMD_POP], cmd_seen[CMD_BULK_PUSH],
               cmd_seen[CMD_BULK_POP]);
      $display("%0d beats checked, %0d empty-list answers, longest batch %0d, %0d mismatches",
               beats_seen, empties, longest_cut, mismatches);
      if (mismatches == 0 && due_grants.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog: sized for the slowest legal run (64 beats per item, full stalls),
   // so 20 ms of 12 ns cycles ends a hung run as broken
   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== free_list_block_allocator_core.f =====
design/fla_pkg.sv
design/fla_front.sv
design/fla_back.sv
design/free_list_block_allocator_core.sv
tb/tb_free_list_block_allocator_core.sv
